// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion wrappers shared by the lzw encoder modules, removable as a group
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset only
`define LZWE_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset only
`define LZWE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LZWE_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define LZWE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// lzwe_pkg
// shared constants, types and records of the gif lzw code stream encoder
// ----------------------------------------------------------------------------
`default_nettype none

package lzwe_pkg;

    // symbol and code sizes
    localparam int SYMBOL_BITS   = 8;
    localparam int MAX_CODE_BITS = 12;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int CODE_LIMIT    = (1 << MAX_CODE_BITS) - 1;
    localparam int WIDTH_W       = 4;
    localparam int CFG_W         = 4;
    localparam int MIN_CODE_LOW  = 2;
    localparam int MIN_CODE_RST  = 8;
    localparam int BYTE_W        = 8;

    // dictionary of child codes, tagged with the table generation
    localparam int ADDR_W        = MAX_CODE_BITS + SYMBOL_BITS;
    localparam int CHILD_DEPTH   = 1 << ADDR_W;
    localparam int EPOCH_W       = 8;
    localparam int EPOCH_MAX     = (1 << EPOCH_W) - 1;
    localparam int ENTRY_W       = EPOCH_W + CODE_W;

    // code records and bit packing
    localparam int REC_SLOTS     = 4;
    localparam int SLOT_IDX_W    = $clog2(REC_SLOTS);
    localparam int REC_CNT_W     = $clog2(REC_SLOTS + 1);
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int ACC_W         = MAX_CODE_BITS + BYTE_W - 1;
    localparam int ACC_CNT_W     = $clog2(ACC_W + 1);

    typedef logic [CODE_W-1:0]      t_code;
    typedef logic [CODE_W:0]        t_code_ext;
    typedef logic [WIDTH_W-1:0]     t_width;
    typedef logic [CFG_W-1:0]       t_cfg;
    typedef logic [SYMBOL_BITS-1:0] t_sym;
    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [EPOCH_W-1:0]     t_epoch;
    typedef logic [ENTRY_W-1:0]     t_entry;
    typedef logic [SLOT_IDX_W-1:0]  t_slot_idx;
    typedef logic [REC_CNT_W-1:0]   t_rec_cnt;
    typedef logic [FIFO_PTR_W-1:0]  t_fifo_ptr;
    typedef logic [FIFO_CNT_W-1:0]  t_fifo_cnt;
    typedef logic [ACC_W-1:0]       t_acc;
    typedef logic [ACC_CNT_W-1:0]   t_acc_cnt;
    typedef logic [BYTE_W-1:0]      t_byte;

    // dictionary access from the lookup stage
    typedef struct packed {
        logic   rd_en;
        t_addr  rd_addr;
        logic   wr_en;
        t_addr  wr_addr;
        t_code  wr_code;
        logic   restart;
    } t_dict_req;

    typedef struct packed {
        logic   busy;
        logic   hit;
        t_code  code;
    } t_dict_rsp;

    // one code and its width on the wire
    typedef struct packed {
        t_code  code;
        t_width width;
    } t_code_slot;

    // all codes that one pixel produces, in stream order
    typedef struct packed {
        t_code_slot [REC_SLOTS-1:0] slot;
        t_rec_cnt                   count;
        logic                       last;
    } t_code_rec;

endpackage

`default_nettype wire

// File: rtl/lzwe_dict.sv
// ----------------------------------------------------------------------------
// lzwe_dict
// child code memory with generation tags and a sweep that clears it
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lzwe_dict (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lzwe_pkg::t_dict_req i_req,
    output lzwe_pkg::t_dict_rsp     o_rsp
);

    lzwe_pkg::t_entry    r_mem [lzwe_pkg::CHILD_DEPTH];
    lzwe_pkg::t_entry    r_rd_q;
    lzwe_pkg::t_epoch    r_epoch;
    logic                r_clearing;
    lzwe_pkg::t_addr     r_clr_addr;

    // single write port shared by the sweep and the lookup stage
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= {r_epoch, i_req.wr_code};
        end
        if (i_req.rd_en) begin
            r_rd_q <= r_mem[i_req.rd_addr];
        end
    end

    // generation counter, sweep when the tags run out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= lzwe_pkg::t_epoch'(1);
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + lzwe_pkg::t_addr'(1);
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end else if (i_req.restart) begin
            if (r_epoch == lzwe_pkg::t_epoch'(lzwe_pkg::EPOCH_MAX)) begin
                r_epoch    <= lzwe_pkg::t_epoch'(1);
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end else begin
                r_epoch <= r_epoch + lzwe_pkg::t_epoch'(1);
            end
        end
    end

    always_comb begin
        o_rsp.busy = r_clearing;
        o_rsp.code = r_rd_q[lzwe_pkg::CODE_W-1:0];
        o_rsp.hit  = (r_rd_q[lzwe_pkg::ENTRY_W-1:lzwe_pkg::CODE_W] == r_epoch)
                     && (o_rsp.code != '0);
    end

    `LZWE_ASSERT(a_no_wr_in_sweep, i_clk, i_rst_n, r_clearing, !i_req.wr_en, "write during sweep")
    `LZWE_ASSERT(a_no_rd_in_sweep, i_clk, i_rst_n, r_clearing, !i_req.rd_en, "read during sweep")
    `LZWE_ASSERT_NXT(a_wrap_sweeps, i_clk, i_rst_n, i_req.restart && !r_clearing && (r_epoch == lzwe_pkg::t_epoch'(lzwe_pkg::EPOCH_MAX)), r_clearing && (r_epoch == lzwe_pkg::t_epoch'(1)), "tag wrap without sweep")

endmodule

`default_nettype wire

// File: rtl/lzwe_pack.sv
// ----------------------------------------------------------------------------
// lzwe_pack
// code record queue and lsb-first bit packer with a registered byte output
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lzwe_pack (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lzwe_pkg::t_code_rec i_rec,
    input  wire logic                i_rec_push,
    output logic                     o_rec_ready,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output lzwe_pkg::t_byte          o_out_byte,
    output logic                     o_last_byte
);

    lzwe_pkg::t_code_rec  r_fifo [lzwe_pkg::FIFO_DEPTH];
    lzwe_pkg::t_fifo_ptr  r_wr_ptr;
    lzwe_pkg::t_fifo_ptr  r_rd_ptr;
    lzwe_pkg::t_fifo_cnt  r_cnt;
    lzwe_pkg::t_slot_idx  r_slot;
    lzwe_pkg::t_acc       r_acc;
    lzwe_pkg::t_acc_cnt   r_nbits;
    logic                 r_flush;
    logic                 r_ovalid;
    lzwe_pkg::t_byte      r_obyte;
    logic                 r_olast;

    lzwe_pkg::t_code_rec  head;
    lzwe_pkg::t_code_slot cur;
    logic                 out_free;
    logic                 emit;
    logic                 emit_last;
    lzwe_pkg::t_acc_cnt   bits_after;
    lzwe_pkg::t_acc       acc_after;
    logic                 append;
    lzwe_pkg::t_code_ext  code_mask;
    lzwe_pkg::t_acc       shifted;
    logic                 pop;

    always_comb begin
        head      = r_fifo[r_rd_ptr];
        cur       = head.slot[r_slot];
        out_free  = !r_ovalid || !i_stall;
        // full byte ready, or the padded tail of an image
        emit      = out_free && ((r_nbits >= lzwe_pkg::t_acc_cnt'(lzwe_pkg::BYTE_W))
                    || (r_flush && (r_nbits != '0)));
        emit_last = r_flush && (r_nbits <= lzwe_pkg::t_acc_cnt'(lzwe_pkg::BYTE_W));
        if (!emit) begin
            bits_after = r_nbits;
            acc_after  = r_acc;
        end else begin
            acc_after = r_acc >> lzwe_pkg::BYTE_W;
            if (r_nbits >= lzwe_pkg::t_acc_cnt'(lzwe_pkg::BYTE_W)) begin
                bits_after = r_nbits - lzwe_pkg::t_acc_cnt'(lzwe_pkg::BYTE_W);
            end else begin
                bits_after = '0;
            end
        end
        append    = (r_cnt != '0) && !r_flush
                    && (bits_after < lzwe_pkg::t_acc_cnt'(lzwe_pkg::BYTE_W));
        code_mask = (lzwe_pkg::t_code_ext'(1) << cur.width) - lzwe_pkg::t_code_ext'(1);
        shifted   = lzwe_pkg::t_acc'(cur.code & code_mask[lzwe_pkg::CODE_W-1:0]) << bits_after;
        pop       = append
                    && ((lzwe_pkg::t_rec_cnt'(r_slot) + lzwe_pkg::t_rec_cnt'(1)) == head.count);
    end

    assign o_rec_ready = (r_cnt != lzwe_pkg::t_fifo_cnt'(lzwe_pkg::FIFO_DEPTH));
    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last_byte = r_olast;

    always_ff @(posedge i_clk) begin
        if (i_rec_push) begin
            r_fifo[r_wr_ptr] <= i_rec;
        end
        if (out_free && emit) begin
            r_obyte <= r_acc[lzwe_pkg::BYTE_W-1:0];
            r_olast <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_slot   <= '0;
            r_acc    <= '0;
            r_nbits  <= '0;
            r_flush  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_rec_push) begin
                r_wr_ptr <= r_wr_ptr + lzwe_pkg::t_fifo_ptr'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + lzwe_pkg::t_fifo_ptr'(1);
            end
            case ({i_rec_push, pop})
                2'b10:   r_cnt <= r_cnt + lzwe_pkg::t_fifo_cnt'(1);
                2'b01:   r_cnt <= r_cnt - lzwe_pkg::t_fifo_cnt'(1);
                default: r_cnt <= r_cnt;
            endcase
            if (pop) begin
                r_slot <= '0;
            end else if (append) begin
                r_slot <= r_slot + lzwe_pkg::t_slot_idx'(1);
            end
            r_acc   <= acc_after | (append ? shifted : '0);
            r_nbits <= bits_after
                       + (append ? lzwe_pkg::t_acc_cnt'(cur.width) : lzwe_pkg::t_acc_cnt'(0));
            if (emit && emit_last) begin
                r_flush <= 1'b0;
            end else if (pop && head.last) begin
                r_flush <= 1'b1;
            end
            if (out_free) begin
                r_ovalid <= emit;
            end
        end
    end

    `LZWE_ASSERT(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_cnt <= lzwe_pkg::t_fifo_cnt'(lzwe_pkg::FIFO_DEPTH), "record queue overrun")
    `LZWE_ASSERT(a_flush_has_bits, i_clk, i_rst_n, r_flush, r_nbits != '0, "flush with empty accumulator")
    `LZWE_ASSERT(a_acc_bound, i_clk, i_rst_n, 1'b1, r_nbits <= lzwe_pkg::t_acc_cnt'(lzwe_pkg::ACC_W), "accumulator overfilled")
    `LZWE_ASSERT(a_head_nonempty, i_clk, i_rst_n, r_cnt != '0, head.count != '0, "empty record queued")

endmodule

`default_nettype wire

// File: rtl/gif_lzw_code_stream_encoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_code_stream_encoder
// gif lzw compressor: palette indices in, packed variable-width code bytes out
// ----------------------------------------------------------------------------
// One palette index per transaction goes in, and the packed lzw code stream
// comes out a byte per transaction, codes lsb first. The first pixel of an
// image is preceded by a clear code; a pixel flagged last ends the image with
// the final prefix, the end code and a zero-padded byte flagged last. The
// dictionary is one synchronous memory of 2^20 child codes addressed by
// {prefix, symbol}; each entry carries a generation tag so that emptying the
// table at image start or when it fills up costs no time. A pixel's memory
// read is issued at acceptance; its update and write back yield the prefix
// that the next read needs. After reset, and after every 255th table restart,
// a sweep zeroes all 2^20 memory entries and no pixel is taken meanwhile. The
// byte output is registered, and a small queue of code records decouples the
// byte rate from the pixel rate, so pixels keep flowing while a byte waits.
// The user must write the code size register only with the image idle; the
// block does not enforce it, and writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gif_lzw_code_stream_encoder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire lzwe_pkg::t_cfg       i_min_code_size,
    // pixel channel
    input  wire logic                 i_pix_valid,
    output logic                      o_pix_stall,
    input  wire lzwe_pkg::t_sym       i_pixel_index,
    input  wire logic                 i_last_pixel,
    // byte channel
    output logic                      o_byte_valid,
    input  wire logic                 i_byte_stall,
    output lzwe_pkg::t_byte           o_out_byte,
    output logic                      o_last_byte
);

    // configuration and encoder state
    lzwe_pkg::t_cfg       r_min_code_size;
    logic                 r_started;
    lzwe_pkg::t_code      r_prefix;
    lzwe_pkg::t_code      r_free;
    lzwe_pkg::t_width     r_cw;
    // pixel held in the lookup stage
    logic                 r_busy;
    lzwe_pkg::t_sym       r_sym;
    logic                 r_last;

    lzwe_pkg::t_dict_req  dict_req;
    lzwe_pkg::t_dict_rsp  dict_rsp;
    lzwe_pkg::t_code_rec  rec;
    logic                 rec_ready;
    logic                 rec_push;

    lzwe_pkg::t_cfg       m_eff;
    lzwe_pkg::t_code      clear_code;
    lzwe_pkg::t_code      end_code;
    lzwe_pkg::t_width     cw_init;
    lzwe_pkg::t_code      free_init;
    lzwe_pkg::t_sym       sym_in;
    logic                 accept;
    logic                 done;

    lzwe_pkg::t_code      free_inc;
    lzwe_pkg::t_code_ext  pow_cw;
    logic                 grow;
    lzwe_pkg::t_width     cw_grown;
    logic                 full;
    logic                 miss;
    lzwe_pkg::t_code      n_prefix;
    lzwe_pkg::t_code      n_free;
    lzwe_pkg::t_width     n_cw;
    logic                 n_started;
    lzwe_pkg::t_code_ext  pow_n;
    lzwe_pkg::t_width     end_w;
    lzwe_pkg::t_rec_cnt   slot_k;

    // code size saturated to the legal range, clear and end codes follow
    always_comb begin
        if (r_min_code_size < lzwe_pkg::t_cfg'(lzwe_pkg::MIN_CODE_LOW)) begin
            m_eff = lzwe_pkg::t_cfg'(lzwe_pkg::MIN_CODE_LOW);
        end else if (r_min_code_size > lzwe_pkg::t_cfg'(lzwe_pkg::SYMBOL_BITS)) begin
            m_eff = lzwe_pkg::t_cfg'(lzwe_pkg::SYMBOL_BITS);
        end else begin
            m_eff = r_min_code_size;
        end
        clear_code = lzwe_pkg::t_code'(1) << m_eff;
        end_code   = clear_code + lzwe_pkg::t_code'(1);
        free_init  = clear_code + lzwe_pkg::t_code'(1);
        cw_init    = lzwe_pkg::t_width'(m_eff) + lzwe_pkg::t_width'(1);
        sym_in     = i_pixel_index & lzwe_pkg::t_sym'(clear_code - lzwe_pkg::t_code'(1));
    end

    assign o_cfg_ready = 1'b1;
    // one pixel in the lookup stage at a time, nothing during the sweep
    assign o_pix_stall = r_busy || dict_rsp.busy;
    assign accept      = i_pix_valid && !o_pix_stall;

    // lookup stage: child code is back, decide hit or miss and build codes
    always_comb begin
        free_inc  = r_free + lzwe_pkg::t_code'(1);
        pow_cw    = lzwe_pkg::t_code_ext'(1) << r_cw;
        grow      = (r_cw < lzwe_pkg::t_width'(lzwe_pkg::MAX_CODE_BITS))
                    && (lzwe_pkg::t_code_ext'(free_inc) >= pow_cw);
        cw_grown  = grow ? (r_cw + lzwe_pkg::t_width'(1)) : r_cw;
        full      = free_inc >= lzwe_pkg::t_code'(lzwe_pkg::CODE_LIMIT);
        miss      = r_started && !dict_rsp.hit;

        n_prefix  = r_prefix;
        n_free    = r_free;
        n_cw      = r_cw;
        n_started = r_started;
        rec       = '0;
        slot_k    = '0;

        if (!r_started) begin
            // image start: fresh table, clear code first
            rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].code  = clear_code;
            rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].width = cw_init;
            slot_k    = slot_k + lzwe_pkg::t_rec_cnt'(1);
            n_prefix  = lzwe_pkg::t_code'(r_sym);
            n_cw      = cw_init;
            n_free    = free_init;
            n_started = 1'b1;
        end else if (dict_rsp.hit) begin
            n_prefix = dict_rsp.code;
        end else begin
            // miss: send the prefix, add the new string
            rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].code  = r_prefix;
            rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].width = r_cw;
            slot_k = slot_k + lzwe_pkg::t_rec_cnt'(1);
            if (full) begin
                // table full: clear code at the grown width, then restart
                rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].code  = clear_code;
                rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].width = cw_grown;
                slot_k = slot_k + lzwe_pkg::t_rec_cnt'(1);
                n_cw   = cw_init;
                n_free = free_init;
            end else begin
                n_cw   = cw_grown;
                n_free = free_inc;
            end
            n_prefix = lzwe_pkg::t_code'(r_sym);
        end

        // end code is one bit wider when the decoder widens on the last prefix
        pow_n = lzwe_pkg::t_code_ext'(1) << n_cw;
        if ((n_cw < lzwe_pkg::t_width'(lzwe_pkg::MAX_CODE_BITS))
            && ((lzwe_pkg::t_code_ext'(n_free) + lzwe_pkg::t_code_ext'(1)) == pow_n)) begin
            end_w = n_cw + lzwe_pkg::t_width'(1);
        end else begin
            end_w = n_cw;
        end

        if (r_last) begin
            rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].code  = n_prefix;
            rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].width = n_cw;
            slot_k = slot_k + lzwe_pkg::t_rec_cnt'(1);
            rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].code  = end_code;
            rec.slot[lzwe_pkg::t_slot_idx'(slot_k)].width = end_w;
            slot_k    = slot_k + lzwe_pkg::t_rec_cnt'(1);
            rec.last  = 1'b1;
            n_started = 1'b0;
        end
        rec.count = slot_k;
    end

    // the stage retires once its codes have a place in the queue
    assign done     = r_busy && ((rec.count == '0) || rec_ready);
    assign rec_push = done && (rec.count != '0);

    // read at acceptance, write back on retire; the next read comes after the
    // retire at the earliest, so a write is always seen by the following read
    always_comb begin
        dict_req.rd_en   = accept && r_started;
        dict_req.rd_addr = {r_prefix, sym_in};
        dict_req.wr_en   = done && miss;
        dict_req.wr_addr = {r_prefix, r_sym};
        dict_req.wr_code = free_inc;
        dict_req.restart = done && (!r_started || (miss && full));
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sym  <= sym_in;
            r_last <= i_last_pixel;
        end
        if (done) begin
            r_prefix <= n_prefix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_code_size <= lzwe_pkg::t_cfg'(lzwe_pkg::MIN_CODE_RST);
            r_started       <= 1'b0;
            r_free          <= (lzwe_pkg::t_code'(1) << lzwe_pkg::SYMBOL_BITS)
                               + lzwe_pkg::t_code'(1);
            r_cw            <= lzwe_pkg::t_width'(lzwe_pkg::SYMBOL_BITS + 1);
            r_busy          <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_code_size <= i_min_code_size;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_started <= n_started;
                r_free    <= n_free;
                r_cw      <= n_cw;
            end
        end
    end

    lzwe_dict u_dict (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dict_req),
        .o_rsp   (dict_rsp)
    );

    lzwe_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec),
        .i_rec_push  (rec_push),
        .o_rec_ready (rec_ready),
        .o_valid     (o_byte_valid),
        .i_stall     (i_byte_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    `LZWE_ASSERT(a_no_sweep_in_lookup, i_clk, i_rst_n, r_busy, !dict_rsp.busy, "sweep while a pixel is in lookup")
    `LZWE_ASSERT(a_cw_range, i_clk, i_rst_n, r_started, (r_cw <= lzwe_pkg::t_width'(lzwe_pkg::MAX_CODE_BITS)) && (r_cw > lzwe_pkg::t_width'(lzwe_pkg::MIN_CODE_LOW)), "code width out of range")
    `LZWE_ASSERT(a_free_below_limit, i_clk, i_rst_n, r_started, r_free < lzwe_pkg::t_code'(lzwe_pkg::CODE_LIMIT), "table not restarted when full")
    `LZWE_ASSERT_NXT(a_accept_loads, i_clk, i_rst_n, accept, r_busy, "accepted pixel not in lookup")

endmodule

`default_nettype wire

// File: verif/lzw_stream_checker_pkg.sv
// ----------------------------------------------------------------------------
// lzw_stream_checker_pkg
// predicts the packed lzw byte stream and checks the bytes the encoder sends
// ----------------------------------------------------------------------------
package lzw_stream_checker_pkg;

    import lzwe_pkg::*;

    localparam int MAX_REPORT_LINES = 40;

    typedef struct {
        t_byte data;
        logic  last;
    } t_stream_byte;

    class lzw_stream_checker;

        t_cfg         code_size_reg;
        t_code        child_tab [int];
        t_code        prefix;
        logic         started;
        t_code        free_code;
        t_width       code_width;
        t_byte        bit_buf;
        int           bit_cnt;
        t_stream_byte coded_bytes [$];
        int           bytes_seen;
        int           errors;

        function new();
            code_size_reg = t_cfg'(MIN_CODE_RST);
            restart_table(eff_size());
            prefix      = '0;
            started     = 1'b0;
            bit_buf     = '0;
            bit_cnt     = 0;
            bytes_seen  = 0;
            errors      = 0;
        endfunction

        // palette depth actually used, saturated to the legal range
        function int eff_size();
            int m;
            m = code_size_reg;
            if (m < MIN_CODE_LOW)
                m = MIN_CODE_LOW;
            if (m > SYMBOL_BITS)
                m = SYMBOL_BITS;
            return m;
        endfunction

        function void write_code_size(t_cfg value);
            code_size_reg = value;
        endfunction

        function void restart_table(int m);
            child_tab.delete();
            code_width = t_width'(m + 1);
            free_code  = t_code'((1 << m) + 1);
        endfunction

        // codes go out lsb first, a byte is queued whenever eight bits are in
        function void pack_code(int code, int width);
            for (int i = 0; i < width; i++) begin
                bit_buf[bit_cnt] = code[i];
                bit_cnt++;
                if (bit_cnt == BYTE_W) begin
                    coded_bytes.push_back('{bit_buf, 1'b0});
                    bit_buf = '0;
                    bit_cnt = 0;
                end
            end
        endfunction

        function void note_pixel(t_sym pix, logic last);
            int m;
            int clear_code;
            int sym;
            int key;
            int end_w;
            m          = eff_size();
            clear_code = 1 << m;
            sym        = pix & (clear_code - 1);
            if (!started) begin
                restart_table(m);
                pack_code(clear_code, code_width);
                prefix  = t_code'(sym);
                started = 1'b1;
            end else begin
                key = (int'(prefix) << SYMBOL_BITS) | sym;
                if (child_tab.exists(key)) begin
                    prefix = child_tab[key];
                end else begin
                    pack_code(prefix, code_width);
                    free_code      = free_code + 1'b1;
                    child_tab[key] = free_code;
                    if (code_width < MAX_CODE_BITS && free_code >= (1 << code_width))
                        code_width = code_width + 1'b1;
                    // dictionary full: clear code at the new width, then start over
                    if (free_code >= CODE_LIMIT) begin
                        pack_code(clear_code, code_width);
                        restart_table(m);
                    end
                    prefix = t_code'(sym);
                end
            end
            if (last) begin
                end_w = code_width;
                pack_code(prefix, code_width);
                if (end_w < MAX_CODE_BITS && free_code + 1 == (1 << end_w))
                    end_w++;
                pack_code(clear_code + 1, end_w);
                if (bit_cnt != 0) begin
                    coded_bytes.push_back('{bit_buf, 1'b0});
                    bit_buf = '0;
                    bit_cnt = 0;
                end
                coded_bytes[coded_bytes.size() - 1].last = 1'b1;
                started = 1'b0;
            end
        endfunction

        function int pending();
            return coded_bytes.size();
        endfunction

        task report(string what);
            if (errors < MAX_REPORT_LINES)
                $display("mismatch: %s", what);
            errors++;
        endtask

        task check_byte(t_byte data, logic last);
            t_stream_byte want;
            bytes_seen++;
            if (coded_bytes.size() == 0) begin
                report($sformatf("byte %0d = %02h last %0b, nothing expected",
                                 bytes_seen, data, last));
                return;
            end
            want = coded_bytes.pop_front();
            if (data !== want.data)
                report($sformatf("byte %0d data %02h, expected %02h",
                                 bytes_seen, data, want.data));
            if (last !== want.last)
                report($sformatf("byte %0d last %0b, expected %0b",
                                 bytes_seen, last, want.last));
        endtask

    endclass

endpackage

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the gif lzw code stream encoder
// ----------------------------------------------------------------------------
// Pixels are offered on the pixel channel and every accepted transaction is
// run through a predictor of the lzw byte stream; every byte taken from the
// byte channel is checked against the oldest predicted byte. A directed set
// of short images covers the field extremes and the special cases, then
// random images run under three idling regimes, with a long receiver
// hold-off and a sender pause.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lzwe_pkg::*;
    import lzw_stream_checker_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 40;       // pipeline and code record queue drain
    localparam int HOLD_CYCLES    = 300;      // long receiver hold-off
    localparam int PHASE_ITEMS    = 70;
    localparam int LIMIT_CYCLES   = 4_000_000; // memory sweeps included

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    t_cfg   i_min_code_size;
    logic   i_pix_valid;
    logic   o_pix_stall;
    t_sym   i_pixel_index;
    logic   i_last_pixel;
    logic   o_byte_valid;
    logic   i_byte_stall;
    t_byte  o_out_byte;
    logic   o_last_byte;

    lzw_stream_checker stream_chk;

    // idling odds in percent per cycle, set per phase by the stimulus
    int pix_idle_pct;
    int byte_idle_pct;

    // hold-off requests, counted out by the receiver process
    int hold_asked;
    int hold_taken;
    int hold_left;

    int cycle_count;

    gif_lzw_code_stream_encoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_min_code_size (i_min_code_size),
        .i_pix_valid     (i_pix_valid),
        .o_pix_stall     (o_pix_stall),
        .i_pixel_index   (i_pixel_index),
        .i_last_pixel    (i_last_pixel),
        .o_byte_valid    (o_byte_valid),
        .i_byte_stall    (i_byte_stall),
        .o_out_byte      (o_out_byte),
        .o_last_byte     (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // byte receiver: random stall, or a solid hold-off when one is asked for
    initial begin
        hold_taken = 0;
        hold_left  = 0;
        i_byte_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_taken != hold_asked) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = hold_asked;
            end
            if (hold_left > 0) begin
                i_byte_stall <= 1'b1;
                hold_left--;
            end else begin
                i_byte_stall <= ($urandom_range(99) < byte_idle_pct);
            end
        end
    end

    // every byte transaction is checked as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_byte_valid === 1'b1 && i_byte_stall === 1'b0)
            stream_chk.check_byte(o_out_byte, o_last_byte);
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    // offer one pixel, entered and left at a falling edge; valid stays up
    // for the next call, which lowers it only if it idles first
    task automatic push_pixel(input t_sym sym, input logic last);
        while ($urandom_range(99) < pix_idle_pct) begin
            i_pix_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pix_valid   <= 1'b1;
        i_pixel_index <= sym;
        i_last_pixel  <= last;
        do @(posedge i_clk); while (o_pix_stall !== 1'b0);
        stream_chk.note_pixel(sym, last);
        @(negedge i_clk);
    endtask

    // sender pause: wait for every predicted byte, then let the block go quiet
    task automatic settle();
        i_pix_valid <= 1'b0;
        while (stream_chk.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // code size is only changed with the encoder idle
    task automatic write_code_size(input t_cfg value);
        settle();
        i_cfg_valid     <= 1'b1;
        i_min_code_size <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        stream_chk.write_code_size(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random index from an alphabet of the given size, upper bits random too
    function automatic t_sym make_sym(input int alpha);
        int mask;
        mask = (1 << stream_chk.eff_size()) - 1;
        return t_sym'(($urandom & ~mask) | $urandom_range(alpha - 1, 0));
    endfunction

    // one image; pause_at names a pixel after which the sender waits it out
    task automatic send_image(input int len, input int alpha, input int pause_at);
        for (int i = 0; i < len; i++) begin
            push_pixel(make_sym(alpha), i == len - 1);
            if (i == pause_at)
                settle();
        end
    endtask

    // random images: short ones mostly, small alphabets for long prefix chains
    task automatic run_images(input int target);
        int sent;
        int len;
        int alpha;
        int roll;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(2) == 0)
                write_code_size(t_cfg'($urandom_range(15)));
            roll = $urandom_range(99);
            if (roll < 10)
                len = 1;
            else if (roll < 75)
                len = $urandom_range(24, 2);
            else
                len = $urandom_range(60, 25);
            if ($urandom_range(1) == 0)
                alpha = 1 << stream_chk.eff_size();
            else
                alpha = $urandom_range(4, 1);
            send_image(len, alpha, -1);
            sent += len;
        end
    endtask

    initial begin
        stream_chk    = new();
        pix_idle_pct  = 0;
        byte_idle_pct = 0;
        hold_asked    = 0;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_min_code_size <= t_cfg'(MIN_CODE_RST);
        i_pix_valid     <= 1'b0;
        i_pixel_index   <= '0;
        i_last_pixel    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // one-pixel image at the reset code size, every index bit set
        push_pixel(8'hFF, 1'b1);

        // two new codes straight away, so the end code goes out one bit wider
        write_code_size(t_cfg'(2));
        push_pixel(8'h00, 1'b0);
        push_pixel(8'h01, 1'b0);
        push_pixel(8'h02, 1'b1);

        // masked upper bits, a dictionary hit and the width growing to four
        push_pixel(8'hFC, 1'b0);
        push_pixel(8'hFC, 1'b0);
        push_pixel(8'hFC, 1'b0);
        push_pixel(8'hFC, 1'b0);
        push_pixel(8'h03, 1'b0);
        push_pixel(8'hFC, 1'b1);

        // code size below range, saturates to two
        write_code_size(t_cfg'(0));
        push_pixel(8'h01, 1'b0);
        push_pixel(8'h02, 1'b0);
        push_pixel(8'h03, 1'b1);

        // code size above range, saturates to eight
        write_code_size(t_cfg'(15));
        push_pixel(8'hAA, 1'b0);
        push_pixel(8'h55, 1'b0);
        push_pixel(8'hAA, 1'b0);
        push_pixel(8'h55, 1'b0);
        push_pixel(8'hAA, 1'b0);
        push_pixel(8'h00, 1'b1);

        write_code_size(t_cfg'(1));
        push_pixel(8'h7F, 1'b1);
        write_code_size(t_cfg'(9));
        push_pixel(8'h80, 1'b1);

        // phase one: sender mostly busy, receiver stalls often; a long
        // hold-off backs the encoder up until it stalls its pixel input
        pix_idle_pct  = 6;
        byte_idle_pct = 57;
        write_code_size(t_cfg'(8));
        hold_asked++;
        send_image(40, 1 << SYMBOL_BITS, -1);
        run_images(PHASE_ITEMS);

        // phase two: the other way round, with a pause half way through an image
        pix_idle_pct  = 57;
        byte_idle_pct = 6;
        send_image(20, 1 << stream_chk.eff_size(), 9);
        run_images(PHASE_ITEMS);

        // phase three: no idling
        pix_idle_pct  = 0;
        byte_idle_pct = 0;
        run_images(PHASE_ITEMS);

        settle();
        if (stream_chk.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/lzwe_pkg.sv
rtl/lzwe_dict.sv
rtl/lzwe_pack.sv
rtl/gif_lzw_code_stream_encoder.sv
verif/lzw_stream_checker_pkg.sv
verif/testbench.sv
